/* hw/rtl/rgbhsv_pkg.sv */
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants for the RGB to HSV converter
// Holds the divider cell payload, the sector codes and the one-step
// restoring division used by every cell of the divider chain.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned NqW       = 24;     // numerator/quotient shift width
  localparam int unsigned DivSteps  = NqW;    // one quotient bit per cell
  localparam int unsigned HueW      = 15;
  localparam int unsigned FixW      = 17;
  localparam int unsigned QHueW     = 12;     // hue offset quotient is at most 3840
  localparam logic [15:0] HueSector = 16'd3840;
  localparam logic [15:0] HueTurn   = 16'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  // Partial state of one restoring division
  typedef struct packed {
    logic [ChanW-1:0] rem;  // partial remainder, below den whenever den is nonzero
    logic [NqW-1:0]   nq;   // numerator bits on top, quotient bits shift in below
    logic [ChanW-1:0] den;  // divisor
  } div_t;

  // Payload handed from cell to cell
  typedef struct packed {
    div_t            sat;    // (max-min) * 2^16 / max
    div_t            hue;    // 3840 * |diff| / (max-min)
    logic            gray;   // max equals min
    sector_e         sector;
    logic            neg;    // channel difference is negative
    logic [FixW-1:0] bright;
  } cell_t;

  // One step of restoring division: bring down a numerator bit, try subtract
  function automatic div_t div_step(div_t s);
    logic [ChanW:0] t;
    logic           ge;
    div_t           r;
    t      = {s.rem, s.nq[NqW-1]};
    ge     = (t >= {1'b0, s.den});
    r      = s;
    r.nq   = {s.nq[NqW-2:0], ge};
    r.rem  = ge ? ChanW'(t - {1'b0, s.den}) : t[ChanW-1:0];
    return r;
  endfunction

endpackage

/* hw/rtl/rgbhsv_prep.sv */
// ----------------------------------------------------------------------------
// rgbhsv_prep: front stage of the RGB to HSV converter
// Finds max, min and sector, computes brightness, and loads the initial
// numerators and divisors of both divisions into a register stage.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic [rgbhsv_pkg::ChanW-1:0]         red_i,
  input  logic [rgbhsv_pkg::ChanW-1:0]         green_i,
  input  logic [rgbhsv_pkg::ChanW-1:0]         blue_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output rgbhsv_pkg::cell_t                    data_o
);

  logic [7:0]        mx, mn, dlt, mag;
  logic signed [8:0] diff;
  logic [11:0]       mag15;
  rgbhsv_pkg::cell_t data_d, data_q;
  logic              valid_q;

  // Take max and min, red wins ties for the sector
  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    dlt = mx - mn;
    if (red_i == mx) begin
      data_d.sector = rgbhsv_pkg::SEC_RED;
      diff = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i == mx) begin
      data_d.sector = rgbhsv_pkg::SEC_GREEN;
      diff = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      data_d.sector = rgbhsv_pkg::SEC_BLUE;
      diff = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    mag   = diff[8] ? 8'(-diff) : diff[7:0];
    mag15 = {mag, 4'b0000} - {4'b0000, mag};
    data_d.neg  = diff[8];
    data_d.gray = (dlt == 8'd0);
    // Brightness: mx * 65536 / 255 = mx * 257 + (mx == 255)
    data_d.bright = {1'b0, mx, mx} + {16'd0, (mx == 8'hFF)};
    // Saturation divide: d followed by sixteen zero bits, over max
    data_d.sat.rem = '0;
    data_d.sat.nq  = {dlt, 16'd0};
    data_d.sat.den = mx;
    // Hue divide: 15*|diff| followed by eight zero bits, over delta
    data_d.hue.rem = '0;
    data_d.hue.nq  = {4'd0, mag15, 8'd0};
    data_d.hue.den = dlt;
  end

  assign ready_o = !valid_q || ready_i;

  // Hold valid until the next cell takes the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/rgbhsv_cell.sv */
// ----------------------------------------------------------------------------
// rgbhsv_cell: one cell of the divider chain
// Resolves one quotient bit of the saturation and of the hue division and
// passes the rest of the payload on with its own valid/ready stage.
// ----------------------------------------------------------------------------
module rgbhsv_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  rgbhsv_pkg::cell_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output rgbhsv_pkg::cell_t data_o
);

  rgbhsv_pkg::cell_t data_d, data_q;
  logic              valid_q;

  // Advance both divisions by one bit
  always_comb begin
    data_d     = data_i;
    data_d.sat = rgbhsv_pkg::div_step(data_i.sat);
    data_d.hue = rgbhsv_pkg::div_step(data_i.hue);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hw/rtl/rgbhsv_post.sv */
// ----------------------------------------------------------------------------
// rgbhsv_post: back stage of the RGB to HSV converter
// Turns the finished quotients into hue and saturation, applies the gray
// case and holds the result in the output register.
// ----------------------------------------------------------------------------
module rgbhsv_post (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  rgbhsv_pkg::cell_t              data_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [rgbhsv_pkg::HueW-1:0]    hue_o,
  output logic [rgbhsv_pkg::FixW-1:0]    saturation_o,
  output logic [rgbhsv_pkg::FixW-1:0]    brightness_o
);

  logic [15:0]                   base, off, hs, hue_full;
  logic [rgbhsv_pkg::HueW-1:0]   hue_d, hue_q;
  logic [rgbhsv_pkg::FixW-1:0]   sat_d, sat_q, bright_q;
  logic                          valid_q;

  // Sector base plus floored offset, wrap a negative hue by a full turn
  always_comb begin
    case (data_i.sector)
      rgbhsv_pkg::SEC_RED:   base = 16'd0;
      rgbhsv_pkg::SEC_GREEN: base = {rgbhsv_pkg::HueSector[14:0], 1'b0};
      rgbhsv_pkg::SEC_BLUE:  base = {rgbhsv_pkg::HueSector[13:0], 2'b00};
      default:               base = 16'd0;
    endcase
    off = {4'd0, data_i.hue.nq[rgbhsv_pkg::QHueW-1:0]};
    if (data_i.neg) begin
      off = off + {15'd0, (data_i.hue.rem != '0)};
      hs  = base - off;
    end else begin
      hs  = base + off;
    end
    hue_full = hs[15] ? (hs + rgbhsv_pkg::HueTurn) : hs;
    hue_d    = data_i.gray ? '0 : hue_full[rgbhsv_pkg::HueW-1:0];
    sat_d    = data_i.gray ? '0 : data_i.sat.nq[rgbhsv_pkg::FixW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load the result register on each accepted transfer
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= data_i.bright;
    end
  end

  assign valid_o      = valid_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

/* hw/rtl/rgb888_to_hsv.sv */
// ----------------------------------------------------------------------------
// rgb888_to_hsv: streaming RGB888 to HSV pixel converter
// Converts one pixel per clock, while the output is not stalled, through a chain of restoring divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel (red, green, blue in tdata) and the
//   HSV result leaves on the m_axis channel (hue, saturation, brightness).
//   Each pixel gives exactly one result, in order.
// Throughput: one pixel per clock while the output is not stalled. Each of
//   the 24 divider cells resolves one quotient bit of both the saturation
//   and the hue division, so a new pixel enters every cycle while earlier
//   ones move down the chain. Stages from input to output: front stage,
//   24 divider cells, output register.
// Reset: all stage valid bits clear; the block is empty and ready.
// Stall: when m_axis_tready is low the output register holds its result;
//   empty stages further up still take new pixels, and s_axis_tready drops
//   only once every stage is occupied.
// ----------------------------------------------------------------------------
module rgb888_to_hsv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // hue[14:0], saturation[31:15],
                                      // brightness[48:32], zero[55:49]
);

  localparam int unsigned N = rgbhsv_pkg::DivSteps;

  rgbhsv_pkg::cell_t                 chain_data [N+1];
  logic [N:0]                        chain_valid;
  logic [N:0]                        chain_ready;
  logic [rgbhsv_pkg::HueW-1:0]       hue;
  logic [rgbhsv_pkg::FixW-1:0]       saturation, brightness;

  // Front stage: max, min, sector and divider setup
  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .red_i   (s_axis_tdata[7:0]),
    .green_i (s_axis_tdata[15:8]),
    .blue_i  (s_axis_tdata[23:16]),
    .valid_o (chain_valid[0]),
    .ready_i (chain_ready[0]),
    .data_o  (chain_data[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[i]),
      .ready_o (chain_ready[i]),
      .data_i  (chain_data[i]),
      .valid_o (chain_valid[i+1]),
      .ready_i (chain_ready[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // Back stage: hue assembly and output register
  rgbhsv_post u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_valid[N]),
    .ready_o      (chain_ready[N]),
    .data_i       (chain_data[N]),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .hue_o        (hue),
    .saturation_o (saturation),
    .brightness_o (brightness)
  );

  assign m_axis_tdata = {7'd0, brightness, saturation, hue};

  // Hue stays within one full turn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, hue} < rgbhsv_pkg::HueTurn))
    else $error("hue out of range");

  // Zero saturation only for gray, which also has zero hue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (saturation == '0)) |-> (hue == '0))
    else $error("nonzero hue with zero saturation");

  // Saturation never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (saturation <= 17'h10000))
    else $error("saturation above one");

  // An empty output register lets the whole chain take a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

/* tb/rgbhsv_checker.sv */
// ----------------------------------------------------------------------------
// rgbhsv_checker: scoreboard for the RGB888 to HSV converter
// Watches both stream channels. Each pixel transfer on the input side gets
// its HSV result computed here and queued. Each result transfer on the
// output side is compared, field by field, with the oldest queued result.
// ----------------------------------------------------------------------------
module rgbhsv_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pix_valid_i,
  input  logic        pix_ready_i,
  input  logic [23:0] pix_data_i,    // red[7:0], green[15:8], blue[23:16]
  input  logic        hsv_valid_i,
  input  logic        hsv_ready_i,
  input  logic [55:0] hsv_data_i,    // hue[14:0], saturation[31:15],
                                     // brightness[48:32], zero[55:49]
  output int          fail_cnt_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned HueW = rgbhsv_pkg::HueW;
  localparam int unsigned FixW = rgbhsv_pkg::FixW;

  typedef struct packed {
    logic [FixW-1:0] bright;
    logic [FixW-1:0] sat;
    logic [HueW-1:0] hue;
  } hsv_t;

  localparam int MaxReports = 10;

  hsv_t hsv_expected_q[$];

  // Exact fixed-point HSV of one pixel, quotients rounded toward minus infinity
  function automatic hsv_t hsv_of_pixel(logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue);
    int                  ri, gi, bi;
    int                  mx, mn, spread, base, diff, num, hue;
    rgbhsv_pkg::sector_e sec;
    hsv_t                res;
    ri = red;
    gi = green;
    bi = blue;
    mx = ri;
    mn = ri;
    if (gi > mx) mx = gi;
    if (bi > mx) mx = bi;
    if (gi < mn) mn = gi;
    if (bi < mn) mn = bi;
    spread = mx - mn;
    res.bright = FixW'((mx * 65536) / 255);
    res.sat    = '0;
    res.hue    = '0;
    // gray, black included, keeps hue and saturation at zero
    if (spread != 0) begin
      res.sat = FixW'((spread * 65536) / mx);
      // red wins ties, then green
      if (ri == mx) sec = rgbhsv_pkg::SEC_RED;
      else if (gi == mx) sec = rgbhsv_pkg::SEC_GREEN;
      else sec = rgbhsv_pkg::SEC_BLUE;
      case (sec)
        rgbhsv_pkg::SEC_RED: begin
          base = 0;
          diff = gi - bi;
        end
        rgbhsv_pkg::SEC_GREEN: begin
          base = 2 * spread;
          diff = bi - ri;
        end
        default: begin
          base = 4 * spread;
          diff = ri - gi;
        end
      endcase
      num = int'(rgbhsv_pkg::HueSector) * (base + diff);
      hue = (num >= 0) ? num / spread : -((-num + spread - 1) / spread);
      // wrap negative hue (red sector below zero) into the full turn
      if (hue < 0) hue += int'(rgbhsv_pkg::HueTurn);
      res.hue = HueW'(hue);
    end
    return res;
  endfunction

  // Queue expected results on pixel transfers, compare on result transfers
  always @(posedge clk_i or negedge rst_ni) begin
    hsv_t want, got;
    if (!rst_ni) begin
      hsv_expected_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
    end else begin
      if (hsv_valid_i && hsv_ready_i) begin
        got.hue    = hsv_data_i[14:0];
        got.sat    = hsv_data_i[31:15];
        got.bright = hsv_data_i[48:32];
        if (hsv_expected_q.size() == 0) begin
          if (fail_cnt_o < MaxReports)
            $display("[%0t] unexpected HSV result: hue %0d sat %0d val %0d",
                     $time, got.hue, got.sat, got.bright);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          want = hsv_expected_q.pop_front();
          if (got.hue !== want.hue || got.sat !== want.sat ||
              got.bright !== want.bright) begin
            if (fail_cnt_o < MaxReports) begin
              $write("[%0t] HSV result %0d wrong: expected hue %0d sat %0d val %0d,",
                     $time, checked_o, want.hue, want.sat, want.bright);
              $display(" got hue %0d sat %0d val %0d", got.hue, got.sat, got.bright);
            end
            fail_cnt_o <= fail_cnt_o + 1;
          end
          checked_o <= checked_o + 1;
        end
      end
      if (pix_valid_i && pix_ready_i)
        hsv_expected_q.push_back(hsv_of_pixel(pix_data_i[7:0], pix_data_i[15:8],
                                              pix_data_i[23:16]));
      pending_o <= hsv_expected_q.size();
    end
  end

endmodule

/* tb/tb_rgb888_to_hsv.sv */
// ----------------------------------------------------------------------------
// tb_rgb888_to_hsv: testbench for the streaming RGB888 to HSV converter
// Sends gray, tied-maximum, saturated and wrapped-hue corner pixels, then a
// random mix of pixels, with random gaps on the input and random back
// pressure on the output. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_rgb888_to_hsv;

  localparam int NumRandom  = 550;
  localparam int DrainWait  = 40;
  localparam int CycleLimit = 400000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;    // red[7:0], green[15:8], blue[23:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;          // hue[14:0], saturation[31:15],
                                      // brightness[48:32], zero[55:49]

  int fail_cnt;
  int pending;
  int checked;
  int sent_cnt   = 0;
  int cycle_cnt  = 0;
  bit tx_calm    = 1'b0;
  int ready_hold = 0;
  int rx_phase   = 0;
  bit rx_calm    = 1'b0;

  rgb888_to_hsv i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  rgbhsv_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_i(s_axis_tready),
    .pix_data_i (s_axis_tdata),
    .hsv_valid_i(m_axis_tvalid),
    .hsv_ready_i(m_axis_tready),
    .hsv_data_i (m_axis_tdata),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // Output back pressure: calm stretches alternate with random stalls
  always @(posedge clk_i) begin
    if (rx_phase == 0) begin
      rx_calm  <= ($urandom_range(0, 3) == 0);
      rx_phase <= $urandom_range(50, 300);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (rx_calm || $urandom_range(0, 99) < 65) begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, 6);
    end else begin
      m_axis_tready <= 1'b0;
      ready_hold    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one pixel and hold it until the transfer
  task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                            input logic [7:0] blue);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // Random pixel drawn from one of several shapes
  task automatic send_random_pixel();
    logic [7:0] hi, lo, ch [3];
    int         shape, pick;
    shape = $urandom_range(0, 9);
    hi    = 8'($urandom_range(1, 255));
    lo    = 8'($urandom_range(0, hi - 1));
    case (shape)
      // gray levels
      4: begin
        ch[0] = 8'($urandom_range(0, 255));
        ch[1] = ch[0];
        ch[2] = ch[0];
      end
      // two channels tie for the maximum, or two tie for the minimum
      5: begin
        pick  = $urandom_range(0, 5);
        ch[0] = (pick == 0 || pick == 1 || pick == 3) ? hi : lo;
        ch[1] = (pick == 0 || pick == 2 || pick == 4) ? hi : lo;
        ch[2] = (pick == 1 || pick == 2 || pick == 5) ? hi : lo;
      end
      // channels at the extremes
      6: begin
        for (int i = 0; i < 3; i++) begin
          pick  = $urandom_range(0, 2);
          ch[i] = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
        end
      end
      // nearly gray: spread of zero to two, unless lo + 2 wraps past 255
      7: begin
        for (int i = 0; i < 3; i++) ch[i] = lo + 8'($urandom_range(0, 1));
        ch[2'($urandom_range(0, 2))] = lo + 8'($urandom_range(0, 2));
      end
      // very dark pixels
      8: begin
        for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(0, 3));
      end
      default: begin
        for (int i = 0; i < 3; i++) ch[i] = 8'($urandom_range(0, 255));
      end
    endcase
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  initial begin
    int directed_cnt;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Corner pixels: gray, primaries, tied maxima, hue wrap, tiny spreads
    send_pixel(8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd1,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd0,   8'd0);
    send_pixel(8'd0,   8'd255, 8'd0);
    send_pixel(8'd0,   8'd0,   8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd255, 8'd255);
    send_pixel(8'd255, 8'd0,   8'd255);
    send_pixel(8'd255, 8'd0,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd200, 8'd10,  8'd199);
    send_pixel(8'd1,   8'd0,   8'd0);
    send_pixel(8'd0,   8'd1,   8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0,   8'd254, 8'd255);
    send_pixel(8'd1,   8'd0,   8'd255);
    send_pixel(8'd170, 8'd85,  8'd170);
    send_pixel(8'd85,  8'd170, 8'd85);
    send_pixel(8'd128, 8'd127, 8'd64);
    directed_cnt = sent_cnt;

    // Random pixels, with calm stretches on the input side now and then
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      send_random_pixel();
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker count the last transfer, drain, then allow for stray results
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d pixels: %0d corner cases, the rest random gray, tied, extreme and mixed",
             sent_cnt, directed_cnt);
    $display("Compared %0d HSV results under random input gaps and output stalls", checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
